FILE: hw/rtl/qme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qme_pkg: shared types and constants of the queue machine execute unit
// Holds the kind codes, the decoded command, the result record and helpers.
// ----------------------------------------------------------------------------
package qme_pkg;

    localparam int WORD_W      = 16;
    localparam int QUEUE_DEPTH = 1024;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REG_COUNT   = 26;
    localparam int REG_IDX_W   = 5;
    localparam int TGT_W       = 12;
    localparam int KIND_W      = 5;
    localparam int CHAR_W      = 8;

    // instruction kind codes as they arrive
    typedef enum logic [KIND_W-1:0] {
        K_NOP = 5'd0, K_HALT = 5'd1, K_ADD = 5'd2, K_SUB = 5'd3, K_MUL = 5'd4,
        K_DIV = 5'd5, K_MOD = 5'd6, K_LOAD = 5'd7, K_STORE = 5'd8,
        K_PRINT_Q = 5'd9, K_PRINT_R = 5'd10, K_CHAR_Q = 5'd11, K_CHAR_R = 5'd12,
        K_JMP = 5'd13, K_JZ = 5'd14, K_JEQ = 5'd15, K_JGT = 5'd16,
        K_PUSH_IMM = 5'd17
    } t_kind;

    // operation class seen by the back end
    typedef enum logic [2:0] {
        OP_NOP, OP_HALT, OP_ALU, OP_LOAD, OP_PUSH, OP_PRINT_Q, OP_PRINT_R, OP_JUMP
    } t_op;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD
    } t_alu;

    typedef enum logic [1:0] {
        JC_ALWAYS, JC_ZERO, JC_EQ, JC_GT
    } t_jcond;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_UNDER = 2'd1, ERR_OVER = 2'd2
    } t_err;

    typedef struct packed {
        t_op                  op;
        t_alu                 alu;
        t_jcond               jcond;
        logic                 is_char;
        logic                 push_reg;
        logic [REG_IDX_W-1:0] reg_a;
        logic [REG_IDX_W-1:0] reg_b;
        logic [WORD_W-1:0]    immediate;
        logic [TGT_W-1:0]     target;
    } t_cmd;

    typedef struct packed {
        logic              branch_taken;
        logic [TGT_W-1:0]  branch_target;
        logic              print_valid;
        logic [WORD_W-1:0] print_value;
        logic              print_is_char;
        logic              halted;
        t_err              error;
    } t_res;

    // ring pointer advance with wrap
    function automatic logic [QPTR_W-1:0] qp_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W:0] s;
        s = {1'b0, p} + 1'b1;
        if (s >= (QPTR_W+1)'(QUEUE_DEPTH))
            return '0;
        return s[QPTR_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/qme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qme_ram: generic memory
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module qme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

FILE: hw/rtl/qme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qme_front: instruction intake
// Decodes each kind into an operation class and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module qme_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [qme_pkg::KIND_W-1:0]   i_kind,
    input  logic [qme_pkg::REG_IDX_W-1:0] i_reg_a,
    input  logic [qme_pkg::REG_IDX_W-1:0] i_reg_b,
    input  logic [qme_pkg::WORD_W-1:0]   i_immediate,
    input  logic [qme_pkg::TGT_W-1:0]    i_jump_target,
    output logic                         o_cmd_valid,
    output qme_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_take
);

    qme_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    qme_pkg::t_cmd dec;
    logic          wr_en;

    // classify the kind
    always_comb begin
        dec           = '0;
        dec.op        = qme_pkg::OP_NOP;
        dec.alu       = qme_pkg::ALU_ADD;
        dec.jcond     = qme_pkg::JC_ALWAYS;
        dec.reg_a     = i_reg_a;
        dec.reg_b     = i_reg_b;
        dec.immediate = i_immediate;
        dec.target    = i_jump_target;
        unique case (qme_pkg::t_kind'(i_kind))
            qme_pkg::K_HALT:     dec.op = qme_pkg::OP_HALT;
            qme_pkg::K_ADD: begin
                dec.op  = qme_pkg::OP_ALU;
                dec.alu = qme_pkg::ALU_ADD;
            end
            qme_pkg::K_SUB: begin
                dec.op  = qme_pkg::OP_ALU;
                dec.alu = qme_pkg::ALU_SUB;
            end
            qme_pkg::K_MUL: begin
                dec.op  = qme_pkg::OP_ALU;
                dec.alu = qme_pkg::ALU_MUL;
            end
            qme_pkg::K_DIV: begin
                dec.op  = qme_pkg::OP_ALU;
                dec.alu = qme_pkg::ALU_DIV;
            end
            qme_pkg::K_MOD: begin
                dec.op  = qme_pkg::OP_ALU;
                dec.alu = qme_pkg::ALU_MOD;
            end
            qme_pkg::K_LOAD:     dec.op = qme_pkg::OP_LOAD;
            qme_pkg::K_STORE: begin
                dec.op       = qme_pkg::OP_PUSH;
                dec.push_reg = 1'b1;
            end
            qme_pkg::K_PUSH_IMM: dec.op = qme_pkg::OP_PUSH;
            qme_pkg::K_PRINT_Q:  dec.op = qme_pkg::OP_PRINT_Q;
            qme_pkg::K_CHAR_Q: begin
                dec.op      = qme_pkg::OP_PRINT_Q;
                dec.is_char = 1'b1;
            end
            qme_pkg::K_PRINT_R:  dec.op = qme_pkg::OP_PRINT_R;
            qme_pkg::K_CHAR_R: begin
                dec.op      = qme_pkg::OP_PRINT_R;
                dec.is_char = 1'b1;
            end
            qme_pkg::K_JMP:      dec.op = qme_pkg::OP_JUMP;
            qme_pkg::K_JZ: begin
                dec.op    = qme_pkg::OP_JUMP;
                dec.jcond = qme_pkg::JC_ZERO;
            end
            qme_pkg::K_JEQ: begin
                dec.op    = qme_pkg::OP_JUMP;
                dec.jcond = qme_pkg::JC_EQ;
            end
            qme_pkg::K_JGT: begin
                dec.op    = qme_pkg::OP_JUMP;
                dec.jcond = qme_pkg::JC_GT;
            end
            default:             dec.op = qme_pkg::OP_NOP;
        endcase
    end

    // command queue handshake
    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd];
    assign wr_en       = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, i_cmd_take};
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr] <= dec;
        end
    end

endmodule

FILE: hw/rtl/qme_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qme_div: iterative divider
// Restoring division, one quotient bit per cycle; a zero divisor yields zero.
// ----------------------------------------------------------------------------
module qme_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qme_pkg::WORD_W-1:0] i_dividend,
    input  logic [qme_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [qme_pkg::WORD_W-1:0] o_quot,
    output logic [qme_pkg::WORD_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(qme_pkg::WORD_W);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_zero;
    logic [CNT_W-1:0]           r_cnt;
    logic [qme_pkg::WORD_W-1:0] r_q;
    logic [qme_pkg::WORD_W-1:0] r_r;
    logic [qme_pkg::WORD_W-1:0] r_d;
    logic [qme_pkg::WORD_W:0]   shifted;
    logic                       fits;

    // one restoring step
    assign shifted = {r_r, r_q[qme_pkg::WORD_W-1]};
    assign fits    = (shifted >= {1'b0, r_d});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(qme_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_r    <= '0;
            r_d    <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_q <= {r_q[qme_pkg::WORD_W-2:0], fits};
            r_r <= fits ? qme_pkg::WORD_W'(shifted - {1'b0, r_d})
                        : shifted[qme_pkg::WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q;
    assign o_rem  = r_zero ? '0 : r_r;

endmodule

FILE: hw/rtl/qme_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qme_back: execution sequencer
// Runs one command against the word queue and register file, holds the result.
// ----------------------------------------------------------------------------
module qme_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  qme_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_res_valid,
    output qme_pkg::t_res o_res,
    input  logic          i_res_pop
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} t_state;

    t_state                          r_state, n_state;
    qme_pkg::t_cmd                   r_cmd, n_cmd;
    logic [qme_pkg::QPTR_W-1:0]      r_head, n_head;
    logic [qme_pkg::QPTR_W-1:0]      r_tail, n_tail;
    logic [qme_pkg::QCNT_W-1:0]      r_count, n_count;
    logic [qme_pkg::REG_COUNT-1:0]   r_rvalid;
    logic                            r_va;
    logic                            r_vb;
    qme_pkg::t_res                   r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic                            q_we;
    logic [qme_pkg::WORD_W-1:0]      q_wdata;
    logic [qme_pkg::WORD_W-1:0]      q_x;
    logic [qme_pkg::WORD_W-1:0]      q_y;
    logic                            rf_we;
    logic [qme_pkg::WORD_W-1:0]      rf_a;
    logic [qme_pkg::WORD_W-1:0]      rf_b;
    logic [qme_pkg::WORD_W-1:0]      ra_val;
    logic [qme_pkg::WORD_W-1:0]      rb_val;
    logic                            take;
    logic                            div_start;
    logic                            div_done;
    logic [qme_pkg::WORD_W-1:0]      div_q;
    logic [qme_pkg::WORD_W-1:0]      div_r;
    logic [2*qme_pkg::WORD_W-1:0]    prod;
    logic [qme_pkg::WORD_W-1:0]      alu_val;
    qme_pkg::t_res                   res;
    logic                            res_fire;

    // word queue storage
    qme_ram #(.WIDTH(qme_pkg::WORD_W), .DEPTH(qme_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_we     (q_we),
        .i_waddr  (r_tail),
        .i_wdata  (q_wdata),
        .i_raddr0 (r_head),
        .i_raddr1 (qme_pkg::qp_inc(r_head)),
        .o_rdata0 (q_x),
        .o_rdata1 (q_y)
    );

    // register file storage, read at both indexes of the incoming command
    qme_ram #(.WIDTH(qme_pkg::WORD_W), .DEPTH(qme_pkg::REG_COUNT)) u_regs (
        .i_clk    (i_clk),
        .i_we     (rf_we),
        .i_waddr  (r_cmd.reg_a),
        .i_wdata  (q_x),
        .i_raddr0 (i_cmd.reg_a),
        .i_raddr1 (i_cmd.reg_b),
        .o_rdata0 (rf_a),
        .o_rdata1 (rf_b)
    );

    qme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (q_x),
        .i_divisor  (q_y),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // never-written registers read as zero
    assign ra_val = r_va ? rf_a : '0;
    assign rb_val = r_vb ? rf_b : '0;

    // combinational add, subtract and multiply
    assign prod = q_x * q_y;
    always_comb begin
        unique case (r_cmd.alu)
            qme_pkg::ALU_ADD: alu_val = q_x + q_y;
            qme_pkg::ALU_SUB: alu_val = q_x - q_y;
            qme_pkg::ALU_MUL: alu_val = prod[qme_pkg::WORD_W-1:0];
            default:          alu_val = '0;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_pop;
        q_we        = 1'b0;
        q_wdata     = '0;
        rf_we       = 1'b0;
        take        = 1'b0;
        div_start   = 1'b0;
        res         = '0;
        res.error   = qme_pkg::ERR_NONE;
        res_fire    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    take    = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.op)
                    qme_pkg::OP_NOP: res_fire = 1'b1;
                    qme_pkg::OP_HALT: begin
                        res.halted = 1'b1;
                        res_fire   = 1'b1;
                    end
                    qme_pkg::OP_ALU: begin
                        if (r_count < qme_pkg::QCNT_W'(2)) begin
                            res.error = qme_pkg::ERR_UNDER;
                            res_fire  = 1'b1;
                        end else if (r_cmd.alu == qme_pkg::ALU_DIV
                                     || r_cmd.alu == qme_pkg::ALU_MOD) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            q_we     = 1'b1;
                            q_wdata  = alu_val;
                            n_head   = qme_pkg::qp_inc(qme_pkg::qp_inc(r_head));
                            n_tail   = qme_pkg::qp_inc(r_tail);
                            n_count  = r_count - 1'b1;
                            res_fire = 1'b1;
                        end
                    end
                    qme_pkg::OP_LOAD: begin
                        if (r_count == '0) begin
                            res.error = qme_pkg::ERR_UNDER;
                        end else begin
                            rf_we   = (r_cmd.reg_a < qme_pkg::REG_IDX_W'(qme_pkg::REG_COUNT));
                            n_head  = qme_pkg::qp_inc(r_head);
                            n_count = r_count - 1'b1;
                        end
                        res_fire = 1'b1;
                    end
                    qme_pkg::OP_PUSH: begin
                        if (r_count >= qme_pkg::QCNT_W'(qme_pkg::QUEUE_DEPTH)) begin
                            res.error = qme_pkg::ERR_OVER;
                        end else begin
                            q_we    = 1'b1;
                            q_wdata = r_cmd.push_reg ? ra_val : r_cmd.immediate;
                            n_tail  = qme_pkg::qp_inc(r_tail);
                            n_count = r_count + 1'b1;
                        end
                        res_fire = 1'b1;
                    end
                    qme_pkg::OP_PRINT_Q: begin
                        if (r_count == '0) begin
                            res.error = qme_pkg::ERR_UNDER;
                        end else begin
                            res.print_valid   = 1'b1;
                            res.print_is_char = r_cmd.is_char;
                            res.print_value   = r_cmd.is_char
                                ? {{(qme_pkg::WORD_W-qme_pkg::CHAR_W){1'b0}},
                                   q_x[qme_pkg::CHAR_W-1:0]}
                                : q_x;
                            n_head  = qme_pkg::qp_inc(r_head);
                            n_count = r_count - 1'b1;
                        end
                        res_fire = 1'b1;
                    end
                    qme_pkg::OP_PRINT_R: begin
                        res.print_valid   = 1'b1;
                        res.print_is_char = r_cmd.is_char;
                        res.print_value   = r_cmd.is_char
                            ? {{(qme_pkg::WORD_W-qme_pkg::CHAR_W){1'b0}},
                               ra_val[qme_pkg::CHAR_W-1:0]}
                            : ra_val;
                        res_fire = 1'b1;
                    end
                    qme_pkg::OP_JUMP: begin
                        unique case (r_cmd.jcond)
                            qme_pkg::JC_ALWAYS: res.branch_taken = 1'b1;
                            qme_pkg::JC_ZERO:   res.branch_taken = (ra_val == '0);
                            qme_pkg::JC_EQ:     res.branch_taken = (ra_val == rb_val);
                            qme_pkg::JC_GT:     res.branch_taken = (ra_val > rb_val);
                            default:            res.branch_taken = 1'b0;
                        endcase
                        res.branch_target = res.branch_taken ? r_cmd.target : '0;
                        res_fire = 1'b1;
                    end
                    default: res_fire = 1'b1;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    q_we     = 1'b1;
                    q_wdata  = (r_cmd.alu == qme_pkg::ALU_DIV) ? div_q : div_r;
                    n_head   = qme_pkg::qp_inc(qme_pkg::qp_inc(r_head));
                    n_tail   = qme_pkg::qp_inc(r_tail);
                    n_count  = r_count - 1'b1;
                    res_fire = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // result register
        if (res_fire) begin
            n_out       = res;
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (rf_we) begin
                r_rvalid[r_cmd.reg_a] <= 1'b1;
            end
        end
        r_cmd <= n_cmd;
        r_out <= n_out;
        r_va  <= (i_cmd.reg_a < qme_pkg::REG_IDX_W'(qme_pkg::REG_COUNT))
                 && r_rvalid[i_cmd.reg_a];
        r_vb  <= (i_cmd.reg_b < qme_pkg::REG_IDX_W'(qme_pkg::REG_COUNT))
                 && r_rvalid[i_cmd.reg_b];
    end

    assign o_cmd_take  = take;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= qme_pkg::QCNT_W'(qme_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (r_state == S_IDLE) && !r_out_valid)
        else $error("command taken while busy");

    a_fire_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_fire |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result not registered");

    a_div_only_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cmd.op == qme_pkg::OP_ALU))
        else $error("divider wait without arithmetic op");

endmodule

FILE: hw/rtl/queue_machine_execute_unit.sv
`timescale 1ns / 1ps
// Flow: an instruction is queued in the front end, taken by the sequencer when idle, executed,
// and its result registered for popping; div and mod first wait in the bit-per-cycle divider.
// The sequencer takes no new command until the previous result has been popped.
// Reset (synchronous, active low) empties the word queue and the result register
// and makes every register a to z read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// queue_machine_execute_unit: queue machine instruction executor
// Front end decodes and buffers instructions, back end executes them in order.
// ----------------------------------------------------------------------------
module queue_machine_execute_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [qme_pkg::KIND_W-1:0]    i_kind,
    input  logic [qme_pkg::REG_IDX_W-1:0] i_reg_a,
    input  logic [qme_pkg::REG_IDX_W-1:0] i_reg_b,
    input  logic [qme_pkg::WORD_W-1:0]    i_immediate,
    input  logic [qme_pkg::TGT_W-1:0]     i_jump_target,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_branch_taken,
    output logic [qme_pkg::TGT_W-1:0]     o_branch_target,
    output logic                          o_print_valid,
    output logic [qme_pkg::WORD_W-1:0]    o_print_value,
    output logic                          o_print_is_char,
    output logic                          o_halted,
    output logic [1:0]                    o_error
);

    logic          cmd_valid;
    qme_pkg::t_cmd cmd;
    logic          cmd_take;
    logic          res_valid;
    qme_pkg::t_res res;

    qme_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_kind        (i_kind),
        .i_reg_a       (i_reg_a),
        .i_reg_b       (i_reg_b),
        .i_immediate   (i_immediate),
        .i_jump_target (i_jump_target),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    qme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (i_pop)
    );

    // result ports
    assign o_empty         = !res_valid;
    assign o_branch_taken  = res.branch_taken;
    assign o_branch_target = res.branch_target;
    assign o_print_valid   = res.print_valid;
    assign o_print_value   = res.print_value;
    assign o_print_is_char = res.print_is_char;
    assign o_halted        = res.halted;
    assign o_error         = res.error;

endmodule

FILE: bench/tb_queue_machine_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_queue_machine_execute_unit: self-checking bench for the execute unit
// Drives instructions through the input queue, predicts each result
// with an internal model of the word queue and register file, and compares
// every popped result with the prediction. Random idling on both sides.
// ----------------------------------------------------------------------------
module tb_queue_machine_execute_unit;

    typedef struct packed {
        logic [qme_pkg::KIND_W-1:0]    kind;
        logic [qme_pkg::REG_IDX_W-1:0] reg_a;
        logic [qme_pkg::REG_IDX_W-1:0] reg_b;
        logic [qme_pkg::WORD_W-1:0]    immediate;
        logic [qme_pkg::TGT_W-1:0]     target;
    } t_instr;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_push = 1'b0;
    logic                          o_full;
    logic [qme_pkg::KIND_W-1:0]    i_kind = '0;
    logic [qme_pkg::REG_IDX_W-1:0] i_reg_a = '0;
    logic [qme_pkg::REG_IDX_W-1:0] i_reg_b = '0;
    logic [qme_pkg::WORD_W-1:0]    i_immediate = '0;
    logic [qme_pkg::TGT_W-1:0]     i_jump_target = '0;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic                          o_branch_taken;
    logic [qme_pkg::TGT_W-1:0]     o_branch_target;
    logic                          o_print_valid;
    logic [qme_pkg::WORD_W-1:0]    o_print_value;
    logic                          o_print_is_char;
    logic                          o_halted;
    logic [1:0]                    o_error;

    queue_machine_execute_unit uut (.*);

    always #2 i_clk = ~i_clk;

    // model state
    logic [qme_pkg::WORD_W-1:0] model_regs [qme_pkg::REG_COUNT];
    logic [qme_pkg::WORD_W-1:0] model_words [$];
    int                model_depth;   // words queued once every generated item runs

    t_instr          pending_instrs [$];
    qme_pkg::t_res   expected_results [$];
    int      error_count = 0;
    int      idle_pct = 19;
    bit      hold_sender = 1'b0;
    int      stall_cycles = 0;

    function automatic logic [qme_pkg::WORD_W-1:0] model_reg(
        input logic [qme_pkg::REG_IDX_W-1:0] idx);
        return (idx < qme_pkg::REG_COUNT) ? model_regs[idx] : '0;
    endfunction

    // execute one instruction on the model state
    function automatic qme_pkg::t_res execute_instr(input t_instr ins);
        qme_pkg::t_res r;
        logic [qme_pkg::WORD_W-1:0] x, y, v;
        r = '0;
        r.error = qme_pkg::ERR_NONE;
        case (ins.kind)
            qme_pkg::K_HALT: r.halted = 1'b1;
            qme_pkg::K_ADD, qme_pkg::K_SUB, qme_pkg::K_MUL, qme_pkg::K_DIV,
            qme_pkg::K_MOD: begin
                if (model_words.size() < 2) begin
                    r.error = qme_pkg::ERR_UNDER;
                end else begin
                    x = model_words.pop_front();
                    y = model_words.pop_front();
                    case (ins.kind)
                        qme_pkg::K_ADD: v = x + y;
                        qme_pkg::K_SUB: v = x - y;
                        qme_pkg::K_MUL: v = x * y;
                        qme_pkg::K_DIV: v = (y == 0) ? '0 : x / y;
                        default: v = (y == 0) ? '0 : x % y;
                    endcase
                    model_words.push_back(v);
                end
            end
            qme_pkg::K_LOAD: begin
                if (model_words.size() < 1) begin
                    r.error = qme_pkg::ERR_UNDER;
                end else begin
                    x = model_words.pop_front();
                    if (ins.reg_a < qme_pkg::REG_COUNT) model_regs[ins.reg_a] = x;
                end
            end
            qme_pkg::K_STORE, qme_pkg::K_PUSH_IMM: begin
                if (model_words.size() >= qme_pkg::QUEUE_DEPTH) r.error = qme_pkg::ERR_OVER;
                else model_words.push_back(ins.kind == qme_pkg::K_STORE ?
                                           model_reg(ins.reg_a) : ins.immediate);
            end
            qme_pkg::K_PRINT_Q, qme_pkg::K_CHAR_Q: begin
                if (model_words.size() < 1) begin
                    r.error = qme_pkg::ERR_UNDER;
                end else begin
                    x = model_words.pop_front();
                    r.print_valid = 1'b1;
                    if (ins.kind == qme_pkg::K_CHAR_Q) begin
                        r.print_is_char = 1'b1;
                        x = {8'h00, x[7:0]};
                    end
                    r.print_value = x;
                end
            end
            qme_pkg::K_PRINT_R: begin
                r.print_valid = 1'b1;
                r.print_value = model_reg(ins.reg_a);
            end
            qme_pkg::K_CHAR_R: begin
                v = model_reg(ins.reg_a);
                r.print_valid = 1'b1;
                r.print_is_char = 1'b1;
                r.print_value = {8'h00, v[7:0]};
            end
            qme_pkg::K_JMP: r.branch_taken = 1'b1;
            qme_pkg::K_JZ:  r.branch_taken = (model_reg(ins.reg_a) == 0);
            qme_pkg::K_JEQ: r.branch_taken = (model_reg(ins.reg_a) == model_reg(ins.reg_b));
            qme_pkg::K_JGT: r.branch_taken = (model_reg(ins.reg_a) > model_reg(ins.reg_b));
            default: ;
        endcase
        if (r.branch_taken) r.branch_target = ins.target;
        return r;
    endfunction

    // queue an instruction for the driver
    task automatic add_instr(input qme_pkg::t_kind k, input int ra, input int rb,
                             input logic [qme_pkg::WORD_W-1:0] imm,
                             input logic [qme_pkg::TGT_W-1:0] tgt);
        t_instr ins;
        ins.kind = k;
        ins.reg_a = ra[qme_pkg::REG_IDX_W-1:0];
        ins.reg_b = rb[qme_pkg::REG_IDX_W-1:0];
        ins.immediate = imm;
        ins.target = tgt;
        pending_instrs.push_back(ins);
    endtask

    task automatic add_raw(input logic [qme_pkg::KIND_W-1:0] k);
        t_instr ins;
        ins.kind = k;
        ins.reg_a = qme_pkg::REG_IDX_W'($urandom);
        ins.reg_b = qme_pkg::REG_IDX_W'($urandom);
        ins.immediate = qme_pkg::WORD_W'($urandom);
        ins.target = qme_pkg::TGT_W'($urandom);
        pending_instrs.push_back(ins);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (!(i_push && o_full) || !i_push) begin
            // previous transfer happened or nothing was offered
            if (i_push && !o_full) begin
                t_instr done;
                done = pending_instrs.pop_front();
                expected_results.push_back(execute_instr(done));
            end
            if (pending_instrs.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= idle_pct) begin
                i_push        <= 1'b1;
                i_kind        <= pending_instrs[0].kind;
                i_reg_a       <= pending_instrs[0].reg_a;
                i_reg_b       <= pending_instrs[0].reg_b;
                i_immediate   <= pending_instrs[0].immediate;
                i_jump_target <= pending_instrs[0].target;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                qme_pkg::t_res got, want;
                got.branch_taken  = o_branch_taken;
                got.branch_target = o_branch_target;
                got.print_valid   = o_print_valid;
                got.print_value   = o_print_value;
                got.print_is_char = o_print_is_char;
                got.halted        = o_halted;
                got.error         = qme_pkg::t_err'(o_error);
                if (expected_results.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        error_count <= error_count + 1;
                        if (error_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            i_pop <= ($urandom_range(99, 0) >= idle_pct);
            // watchdog on cycles with no transfer
            if ((i_push && !o_full) || (i_pop && !o_empty)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("queue_machine_execute_unit verification failed");
                $finish;
            end
        end
    end

    // random body: mostly well-formed, keeping the queue non-negative
    task automatic add_random(input int n);
        int depth, pick;
        depth = model_depth;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            if (depth < 2 && pick < 60) pick = 60;
            if (pick < 25) begin
                add_instr(qme_pkg::t_kind'($urandom_range(qme_pkg::K_MOD, qme_pkg::K_ADD)),
                          0, 0, 0, 0);
                depth--;
            end else if (pick < 35) begin
                add_instr(qme_pkg::K_LOAD, $urandom_range(31, 0), 0, 0, 0);
                depth--;
            end else if (pick < 45) begin
                add_instr($urandom_range(1, 0) ? qme_pkg::K_PRINT_Q : qme_pkg::K_CHAR_Q,
                          0, 0, 0, 0);
                depth--;
            end else if (pick < 60 && depth > 0 && $urandom_range(9, 0) == 0) begin
                // unknown kinds act as nop
                add_raw(qme_pkg::KIND_W'($urandom_range(31, 18)));
            end else if (pick < 80) begin
                if (depth < qme_pkg::QUEUE_DEPTH) depth++;
                add_instr($urandom_range(1, 0) ? qme_pkg::K_PUSH_IMM : qme_pkg::K_STORE,
                          $urandom_range(31, 0), 0, qme_pkg::WORD_W'($urandom), 0);
            end else if (pick < 95) begin
                add_instr(qme_pkg::t_kind'(
                          $urandom_range(qme_pkg::K_CHAR_R, qme_pkg::K_PRINT_R)
                              == qme_pkg::K_PRINT_R ?
                          ($urandom_range(1, 0) ? qme_pkg::K_PRINT_R : qme_pkg::K_JZ) :
                          $urandom_range(qme_pkg::K_JGT, qme_pkg::K_JMP)),
                          $urandom_range(31, 0), $urandom_range(31, 0), 0,
                          qme_pkg::TGT_W'($urandom));
            end else begin
                add_raw($urandom_range(1, 0) ? qme_pkg::K_HALT : qme_pkg::K_NOP);
            end
        end
        model_depth = depth;
    endtask

    initial begin
        model_depth = 0;
        foreach (model_regs[i]) model_regs[i] = '0;
        // directed: underflows on the empty queue, then every kind but nop, plus an unknown kind
        add_instr(qme_pkg::K_ADD, 0, 0, 0, 0);
        add_instr(qme_pkg::K_LOAD, 0, 0, 0, 0);
        add_instr(qme_pkg::K_PRINT_Q, 0, 0, 0, 0);
        add_instr(qme_pkg::K_CHAR_Q, 0, 0, 0, 0);
        add_instr(qme_pkg::K_PUSH_IMM, 0, 0, 16'hffff, 0);
        add_instr(qme_pkg::K_PUSH_IMM, 0, 0, 16'h0000, 0);
        add_instr(qme_pkg::K_DIV, 0, 0, 0, 0);
        add_instr(qme_pkg::K_PUSH_IMM, 0, 0, 16'h0000, 0);
        add_instr(qme_pkg::K_MOD, 0, 0, 0, 0);
        add_instr(qme_pkg::K_LOAD, 25, 0, 0, 0);
        add_instr(qme_pkg::K_PUSH_IMM, 0, 0, 16'h1234, 0);
        add_instr(qme_pkg::K_LOAD, 31, 0, 0, 0);
        add_instr(qme_pkg::K_STORE, 25, 0, 0, 0);
        add_instr(qme_pkg::K_STORE, 30, 0, 0, 0);
        add_instr(qme_pkg::K_SUB, 0, 0, 0, 0);
        add_instr(qme_pkg::K_CHAR_Q, 0, 0, 0, 0);
        add_instr(qme_pkg::K_PRINT_R, 25, 0, 0, 0);
        add_instr(qme_pkg::K_CHAR_R, 25, 0, 0, 0);
        add_instr(qme_pkg::K_JMP, 0, 0, 0, 12'hfff);
        add_instr(qme_pkg::K_JZ, 0, 0, 0, 12'h001);
        add_instr(qme_pkg::K_JEQ, 0, 31, 0, 12'h800);
        add_instr(qme_pkg::K_JGT, 25, 0, 0, 12'h7ff);
        add_instr(qme_pkg::K_HALT, 0, 0, 0, 0);
        add_raw(5'd31);
        add_instr(qme_pkg::K_MUL, 0, 0, 0, 0);
        model_depth = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_random(300);
        // wait for the pipeline to drain before the quiet stretch
        wait (pending_instrs.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        repeat (30) @(posedge i_clk);
        hold_sender = 1'b0;

        // stretch with no idling on either side
        idle_pct = 0;
        add_random(150);
        wait (pending_instrs.size() == 0);
        idle_pct = 19;

        add_random(325);
        wait (pending_instrs.size() == 0);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("queue_machine_execute_unit verification clean");
        else
            $display("queue_machine_execute_unit verification failed");
        $finish;
    end

endmodule
